[hdl/mcmp_pkg.sv]
package mcmp_pkg;

	// One input request of the command channel.
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] module_row;
		logic [7:0] module_col;
		logic       module_value;
		logic [7:0] codeword_in;
	} req_t;

	// One result of the response channel.
	typedef struct packed {
		logic [7:0]  codeword_out;
		logic [10:0] codeword_index;
		logic        placed;
		logic        walk_done;
		logic        module_on;
		logic [10:0] codeword_count;
	} rsp_t;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MAP_ROWS = 2'd0;
	localparam cfg_idx_t REG_MAP_COLS = 2'd1;

	// Action codes of a request.
	localparam logic [2:0] ACT_LOAD   = 3'd0;
	localparam logic [2:0] ACT_PLACE  = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_FINISH = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Bit positions of the marks of one module.
	localparam int MK_ON       = 0;
	localparam int MK_ASSIGNED = 1;
	localparam int MK_VISITED  = 2;
	typedef logic [2:0] mark_t;

	// Phases of the diagonal walk.
	typedef enum logic [1:0] {
		PH_CORNER,
		PH_UP,
		PH_DOWN,
		PH_DONE
	} phase_t;

	// Signed walk and module coordinates.
	typedef logic signed [9:0] coord_t;

	// Commands from the controller to the datapath.
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_CLR_START,
		CMD_CLR_STEP,
		CMD_RD_XY,
		CMD_LOAD_WR,
		CMD_READ_RES,
		CMD_RD_LAST,
		CMD_FIN_WR,
		CMD_RD_LAST2,
		CMD_FIN_WR2,
		CMD_CORNER,
		CMD_RD_WALK,
		CMD_MOD_INIT,
		CMD_MOD_CALC,
		CMD_MOD_RD,
		CMD_MOD_WR,
		CMD_MOD_NEXT,
		CMD_PLACE_RES,
		CMD_EMIT
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] act;
		phase_t     phase;
		logic       fin;
		logic       xy_ok;
		logic       walk_ok;
		logic       free;
		logic       mod_ok;
		logic       last_bit;
		logic       clr_last;
		logic       shape_zero;
		logic       out_busy;
	} status_t;

endpackage

[hdl/mcmp_if.sv]
// Command channel.
interface mcmp_req_if;
	logic              valid;
	logic              ready;
	mcmp_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Response channel.
interface mcmp_rsp_if;
	logic              valid;
	logic              ready;
	mcmp_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface mcmp_cfg_if;
	logic               valid;
	logic               ready;
	mcmp_pkg::cfg_idx_t index;
	logic [7:0]         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/matrix_code_module_placement.sv]
// Channel  Dir  Contents                                           Accepted when
// cmd      in   action, module_row, module_col, module_value,     valid && ready
//               codeword_in
// res      out  codeword_out, codeword_index, placed, walk_done,  valid && ready
//               module_on, codeword_count
// cfg      in   index (0 map_rows, 1 map_cols), data              valid && ready
//
// One request is worked at a time. Unknown actions, addresses outside the matrix and a
// place with nothing left to place change nothing in the store.
// A place tries walk positions along the diagonal, then for each module of the codeword
// computes the address, then reads the store and writes it back (address, store read,
// store write); a module outside the matrix skips the read and the write.
// After reset, and for a clear action, a clearing pass writes all MAX_MAP_DIM squared
// entries, one a cycle (17424 entries at the default), before the next request.
// A finished result waits in the output register; cfg is always ready.
module matrix_code_module_placement #(
	parameter int MAX_MAP_DIM = 132
) (
	input logic         clk,
	input logic         arst_n,
	mcmp_req_if.sink    cmd,
	mcmp_rsp_if.source  res,
	mcmp_cfg_if.sink    cfg
);
	import mcmp_pkg::*;

	cmd_t    dp_cmd;
	status_t dp_st;

	mcmp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(cmd.valid), .req_ready(cmd.ready),
		.st(dp_st), .cmd(dp_cmd)
	);

	mcmp_datapath #(.MAX_MAP_DIM(MAX_MAP_DIM)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dp_cmd), .st(dp_st), .req(cmd.data),
		.res(res), .cfg(cfg)
	);
endmodule

[hdl/mcmp_ram.sv]
module mcmp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 17424
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hdl/mcmp_datapath.sv]
module mcmp_datapath #(
	parameter int MAX_MAP_DIM = 132
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcmp_pkg::cmd_t    cmd,
	output mcmp_pkg::status_t st,
	input  mcmp_pkg::req_t    req,
	mcmp_rsp_if.source        res,
	mcmp_cfg_if.sink          cfg
);
	import mcmp_pkg::*;

	localparam int DEPTH = MAX_MAP_DIM * MAX_MAP_DIM;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {SH_STD, SH_C1, SH_C2, SH_C3, SH_C4} shape_t;

	localparam coord_t SR [8] = '{-10'sd2, -10'sd2, -10'sd1, -10'sd1,
		-10'sd1, 10'sd0, 10'sd0, 10'sd0};
	localparam coord_t SC [8] = '{-10'sd2, -10'sd1, -10'sd2, -10'sd1,
		10'sd0, -10'sd2, -10'sd1, 10'sd0};

	logic [7:0] rows_q, cols_q, nr, nc;
	coord_t     nr_c, nc_c;
	logic [2:0] act_q;
	logic [7:0] in_r_q, in_c_q, cw_q;
	logic       in_val_q;
	coord_t     walk_row_q, walk_col_q, anc_r_q, anc_c_q, mod_r_q, mod_c_q;
	phase_t     phase_q;
	logic [10:0] count_q, idx_q;
	logic       fin_q, mod_ok_q, placed_q, on_q;
	shape_t     shape_q, sh;
	logic [2:0] i_q;
	logic [7:0] cw_out_q;
	logic [AW-1:0] addr_q, clr_q;
	rsp_t       res_q;
	logic       res_valid_q;

	logic          re, we;
	logic [AW-1:0] raddr, waddr;
	mark_t         wdata, rdata;

	coord_t     next_row, next_col;
	phase_t     next_phase;
	coord_t     tab_r [8];
	coord_t     tab_c [8];
	coord_t     mr, mc;
	logic       m_ok, walk_ok;
	logic [15:0] xy_prod, walk_prod, mod_prod, last_prod;
	logic [AW-1:0] xy_addr, walk_addr, mod_addr, last_addr, last2_addr;
	logic [2:0] bitpos;
	logic       cw_bit;
	mark_t      mod_wdata;
	logic       mod_newbit;

	function automatic logic [7:0] dim_of(input logic [7:0] v);
		if (v < 8'd6) return 8'd6;
		if (v > 8'(MAX_MAP_DIM)) return 8'(MAX_MAP_DIM);
		return v;
	endfunction

	assign nr = dim_of(rows_q);
	assign nc = dim_of(cols_q);
	assign nr_c = $signed({2'b00, nr});
	assign nc_c = $signed({2'b00, nc});

	// Configuration registers, always writable.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd8;
			cols_q <= 8'd8;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MAP_ROWS) rows_q <= cfg.data;
			if (cfg.index == REG_MAP_COLS) cols_q <= cfg.data;
		end
	end

	// Corner shape selected at the current walk position.
	always_comb begin
		sh = SH_STD;
		if (walk_row_q == nr_c && walk_col_q == 10'sd0) begin
			sh = SH_C1;
		end else if (walk_row_q == nr_c - 10'sd2 && walk_col_q == 10'sd0 && nc[1:0] != 2'd0) begin
			sh = SH_C2;
		end else if (walk_row_q == nr_c - 10'sd2 && walk_col_q == 10'sd0 && nc[2:0] == 3'd4) begin
			sh = SH_C3;
		end else if (walk_row_q == nr_c + 10'sd4 && walk_col_q == 10'sd2 && nc[2:0] == 3'd0) begin
			sh = SH_C4;
		end
	end

	// Cursor advance along the diagonal.
	always_comb begin
		next_row = walk_row_q;
		next_col = walk_col_q;
		next_phase = phase_q;
		if (phase_q == PH_UP) begin
			next_row = walk_row_q - 10'sd2;
			next_col = walk_col_q + 10'sd2;
			if (!(next_row >= 10'sd0 && next_col < nc_c)) begin
				next_row = next_row + 10'sd1;
				next_col = next_col + 10'sd3;
				next_phase = PH_DOWN;
			end
		end else if (phase_q == PH_DOWN) begin
			next_row = walk_row_q + 10'sd2;
			next_col = walk_col_q - 10'sd2;
			if (!(next_row < nr_c && next_col >= 10'sd0)) begin
				next_row = next_row + 10'sd3;
				next_col = next_col + 10'sd1;
				next_phase = (next_row < nr_c || next_col < nc_c) ? PH_CORNER : PH_DONE;
			end
		end
	end

	// Module positions of the shape in use, then the edge wrap.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			tab_r[k] = anc_r_q + SR[k];
			tab_c[k] = anc_c_q + SC[k];
		end
		case (shape_q)
			SH_C1: begin
				tab_r = '{nr_c - 10'sd1, nr_c - 10'sd1, nr_c - 10'sd1, 10'sd0,
					10'sd0, 10'sd1, 10'sd2, 10'sd3};
				tab_c = '{10'sd0, 10'sd1, 10'sd2, nc_c - 10'sd2,
					nc_c - 10'sd1, nc_c - 10'sd1, nc_c - 10'sd1, nc_c - 10'sd1};
			end
			SH_C2: begin
				tab_r = '{nr_c - 10'sd3, nr_c - 10'sd2, nr_c - 10'sd1, 10'sd0,
					10'sd0, 10'sd0, 10'sd0, 10'sd1};
				tab_c = '{10'sd0, 10'sd0, 10'sd0, nc_c - 10'sd4,
					nc_c - 10'sd3, nc_c - 10'sd2, nc_c - 10'sd1, nc_c - 10'sd1};
			end
			SH_C3: begin
				tab_r = '{nr_c - 10'sd3, nr_c - 10'sd2, nr_c - 10'sd1, 10'sd0,
					10'sd0, 10'sd1, 10'sd2, 10'sd3};
				tab_c = '{10'sd0, 10'sd0, 10'sd0, nc_c - 10'sd2,
					nc_c - 10'sd1, nc_c - 10'sd1, nc_c - 10'sd1, nc_c - 10'sd1};
			end
			SH_C4: begin
				tab_r = '{nr_c - 10'sd1, nr_c - 10'sd1, 10'sd0, 10'sd0,
					10'sd0, 10'sd1, 10'sd1, 10'sd1};
				tab_c = '{10'sd0, nc_c - 10'sd1, nc_c - 10'sd3, nc_c - 10'sd2,
					nc_c - 10'sd1, nc_c - 10'sd3, nc_c - 10'sd2, nc_c - 10'sd1};
			end
			default: begin
			end
		endcase
		mr = tab_r[i_q];
		mc = tab_c[i_q];
		if (mr < 10'sd0) begin
			mr = mr + nr_c;
			mc = mc + 10'sd4 - $signed({7'd0, nr[2:0] + 3'd4});
		end
		if (mc < 10'sd0) begin
			mc = mc + nc_c;
			mr = mr + 10'sd4 - $signed({7'd0, nc[2:0] + 3'd4});
		end
		m_ok = mr >= 10'sd0 && mr < nr_c && mc >= 10'sd0 && mc < nc_c;
	end

	assign walk_ok = walk_row_q >= 10'sd0 && walk_row_q < nr_c
		&& walk_col_q >= 10'sd0 && walk_col_q < nc_c;

	// Flat store addresses.
	assign xy_prod = in_r_q * nc;
	assign walk_prod = walk_row_q[7:0] * nc;
	assign mod_prod = mod_r_q[7:0] * nc;
	assign last_prod = nr * nc;
	assign xy_addr = AW'(xy_prod + 16'(in_c_q));
	assign walk_addr = AW'(walk_prod + 16'(walk_col_q[7:0]));
	assign mod_addr = AW'(mod_prod + 16'(mod_c_q[7:0]));
	assign last_addr = AW'(last_prod - 16'd1);
	assign last2_addr = addr_q - AW'(nc) - AW'(1);

	// Codeword bit against the read marks.
	assign bitpos = 3'd7 - i_q;
	assign cw_bit = cw_q[bitpos];
	always_comb begin
		mod_wdata = rdata;
		mod_newbit = cw_bit;
		if (rdata[MK_ASSIGNED]) begin
			mod_newbit = rdata[MK_ON];
		end else begin
			mod_wdata[MK_ASSIGNED] = 1'b1;
			if (cw_bit) mod_wdata[MK_ON] = 1'b1;
		end
		mod_wdata[MK_VISITED] = 1'b1;
	end

	// Store port selection per command.
	always_comb begin
		re = 1'b0;
		raddr = xy_addr;
		we = 1'b0;
		waddr = addr_q;
		wdata = rdata;
		case (cmd)
			CMD_RD_XY: re = 1'b1;
			CMD_RD_LAST: begin
				re = 1'b1;
				raddr = last_addr;
			end
			CMD_RD_LAST2: begin
				re = 1'b1;
				raddr = last2_addr;
			end
			CMD_RD_WALK: begin
				re = walk_ok;
				raddr = walk_addr;
			end
			CMD_MOD_RD: begin
				re = 1'b1;
				raddr = mod_addr;
			end
			CMD_CLR_STEP: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			CMD_LOAD_WR: begin
				we = 1'b1;
				wdata[MK_ASSIGNED] = 1'b1;
				wdata[MK_ON] = in_val_q;
			end
			CMD_FIN_WR: begin
				we = !rdata[MK_VISITED];
				wdata[MK_ON] = 1'b1;
			end
			CMD_FIN_WR2: begin
				we = 1'b1;
				wdata[MK_ON] = 1'b1;
			end
			CMD_MOD_WR: begin
				we = mod_ok_q;
				wdata = mod_wdata;
			end
			default: begin
			end
		endcase
	end

	mcmp_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// Walk and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_row_q <= 10'sd4;
			walk_col_q <= 10'sd0;
			phase_q <= PH_CORNER;
			count_q <= '0;
			fin_q <= 1'b0;
			clr_q <= '0;
			i_q <= '0;
			shape_q <= SH_STD;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) res_valid_q <= 1'b0;
			case (cmd)
				CMD_CLR_START: begin
					walk_row_q <= 10'sd4;
					walk_col_q <= 10'sd0;
					phase_q <= PH_CORNER;
					count_q <= '0;
					fin_q <= 1'b0;
					clr_q <= '0;
				end
				CMD_CLR_STEP: clr_q <= clr_q + AW'(1);
				CMD_FIN_WR: fin_q <= 1'b1;
				CMD_CORNER: begin
					phase_q <= PH_UP;
					shape_q <= sh;
					i_q <= '0;
				end
				CMD_RD_WALK: begin
					walk_row_q <= next_row;
					walk_col_q <= next_col;
					phase_q <= next_phase;
				end
				CMD_MOD_INIT: begin
					shape_q <= SH_STD;
					i_q <= '0;
				end
				CMD_MOD_WR, CMD_MOD_NEXT: i_q <= i_q + 3'd1;
				CMD_PLACE_RES: count_q <= count_q + 11'd1;
				CMD_EMIT: res_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (re) addr_q <= raddr;
		case (cmd)
			CMD_CAPTURE: begin
				act_q <= req.action;
				in_r_q <= req.module_row;
				in_c_q <= req.module_col;
				in_val_q <= req.module_value;
				cw_q <= req.codeword_in;
				cw_out_q <= '0;
				idx_q <= '0;
				placed_q <= 1'b0;
				on_q <= 1'b0;
			end
			CMD_READ_RES: on_q <= rdata[MK_ON];
			CMD_CORNER: begin
				anc_r_q <= 10'sd0;
				anc_c_q <= 10'sd0;
			end
			CMD_RD_WALK: begin
				anc_r_q <= walk_row_q;
				anc_c_q <= walk_col_q;
			end
			CMD_MOD_CALC: begin
				mod_r_q <= mr;
				mod_c_q <= mc;
				mod_ok_q <= m_ok;
			end
			CMD_MOD_WR: if (mod_ok_q) cw_q[bitpos] <= mod_newbit;
			CMD_PLACE_RES: begin
				cw_out_q <= cw_q;
				idx_q <= count_q;
				placed_q <= 1'b1;
			end
			CMD_EMIT: begin
				res_q.codeword_out <= cw_out_q;
				res_q.codeword_index <= idx_q;
				res_q.placed <= placed_q;
				res_q.walk_done <= phase_q == PH_DONE;
				res_q.module_on <= on_q;
				res_q.codeword_count <= count_q;
			end
			default: begin
			end
		endcase
	end

	assign res.valid = res_valid_q;
	assign res.data = res_q;

	// Status toward the controller.
	assign st.act = act_q;
	assign st.phase = phase_q;
	assign st.fin = fin_q;
	assign st.xy_ok = in_r_q < nr && in_c_q < nc;
	assign st.walk_ok = walk_ok;
	assign st.free = !rdata[MK_VISITED];
	assign st.mod_ok = mod_ok_q;
	assign st.last_bit = i_q == 3'd7;
	assign st.clr_last = clr_q == AW'(DEPTH - 1);
	assign st.shape_zero = sh == SH_STD;
	assign st.out_busy = res_valid_q && !res.ready;
endmodule

[hdl/mcmp_ctrl.sv]
module mcmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mcmp_pkg::status_t st,
	output mcmp_pkg::cmd_t    cmd
);
	import mcmp_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_LOAD_WR, S_READ_RES, S_FIN_CHK,
		S_FIN_RD2, S_FIN_WR2, S_TICK, S_WALK_CHK, S_MOD_CALC, S_MOD_RD,
		S_MOD_WR, S_PLACE, S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   clr_emit_q, clr_emit_d;

	assign req_ready = state_q == S_IDLE && !st.out_busy;

	// Next state and command.
	always_comb begin
		state_d = state_q;
		clr_emit_d = clr_emit_q;
		cmd = CMD_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd = CMD_CLR_STEP;
				if (st.clr_last) state_d = clr_emit_q ? S_EMIT : S_IDLE;
			end
			S_IDLE: begin
				if (req_valid && req_ready) begin
					cmd = CMD_CAPTURE;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.act)
					ACT_READ: begin
						if (st.xy_ok) begin
							cmd = CMD_RD_XY;
							state_d = S_READ_RES;
						end else begin
							state_d = S_EMIT;
						end
					end
					ACT_PLACE: state_d = (st.fin || st.phase == PH_DONE) ? S_EMIT : S_TICK;
					ACT_FINISH: begin
						cmd = CMD_RD_LAST;
						state_d = S_FIN_CHK;
					end
					ACT_CLEAR: begin
						cmd = CMD_CLR_START;
						clr_emit_d = 1'b1;
						state_d = S_CLEAR;
					end
					default: begin
						// Load, and codes without meaning, which change nothing.
						if (st.act == ACT_LOAD && st.xy_ok) begin
							cmd = CMD_RD_XY;
							state_d = S_LOAD_WR;
						end else begin
							state_d = S_EMIT;
						end
					end
				endcase
			end
			S_LOAD_WR: begin
				cmd = CMD_LOAD_WR;
				state_d = S_EMIT;
			end
			S_READ_RES: begin
				cmd = CMD_READ_RES;
				state_d = S_EMIT;
			end
			S_FIN_CHK: begin
				cmd = CMD_FIN_WR;
				state_d = st.free ? S_FIN_RD2 : S_EMIT;
			end
			S_FIN_RD2: begin
				cmd = CMD_RD_LAST2;
				state_d = S_FIN_WR2;
			end
			S_FIN_WR2: begin
				cmd = CMD_FIN_WR2;
				state_d = S_EMIT;
			end
			S_TICK: begin
				if (st.phase == PH_DONE) begin
					state_d = S_EMIT;
				end else if (st.phase == PH_CORNER) begin
					cmd = CMD_CORNER;
					if (!st.shape_zero) state_d = S_MOD_CALC;
				end else begin
					cmd = CMD_RD_WALK;
					if (st.walk_ok) state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				if (st.free) begin
					cmd = CMD_MOD_INIT;
					state_d = S_MOD_CALC;
				end else begin
					state_d = S_TICK;
				end
			end
			S_MOD_CALC: begin
				cmd = CMD_MOD_CALC;
				state_d = S_MOD_RD;
			end
			S_MOD_RD: begin
				if (st.mod_ok) begin
					cmd = CMD_MOD_RD;
					state_d = S_MOD_WR;
				end else begin
					cmd = CMD_MOD_NEXT;
					state_d = st.last_bit ? S_PLACE : S_MOD_CALC;
				end
			end
			S_MOD_WR: begin
				cmd = CMD_MOD_WR;
				state_d = st.last_bit ? S_PLACE : S_MOD_CALC;
			end
			S_PLACE: begin
				cmd = CMD_PLACE_RES;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd = CMD_EMIT;
				clr_emit_d = 1'b0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_emit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_emit_q <= clr_emit_d;
		end
	end
endmodule

[hdl/mcmp_checker.sv]
module mcmp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input logic           res_valid,
	input logic           res_ready,
	input mcmp_pkg::rsp_t res_data
);
	import mcmp_pkg::*;

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A placed codeword advances the count by exactly one.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.placed |->
		res_data.codeword_count == res_data.codeword_index + 11'd1)
		else $error("count does not follow placed index");

	// Without a placement the codeword fields are zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.placed |->
		res_data.codeword_out == 8'd0 && res_data.codeword_index == 11'd0)
		else $error("codeword fields set without placement");

	// Requests are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while busy");
endmodule

bind matrix_code_module_placement mcmp_checker u_mcmp_checker (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
